@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [15:0]        handle;
    logic [7:0]         kind;
    logic signed [15:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic eval;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   cmp_entry,
  input  spq_pkg::entry_t   new_entry,
  input  logic              left_place,
  input  logic              left_valid,
  input  spq_pkg::entry_t   left_entry,
  input  logic              right_valid,
  input  spq_pkg::entry_t   right_entry,
  output logic              place,
  output logic              valid,
  output spq_pkg::entry_t   entry,
  output logic              dup
);

  spq_pkg::entry_t entry_r;
  logic            valid_r;
  logic            dup_r;
  logic            gt_r;

  // place: new entry lands here or further left
  assign place = gt_r | ~valid_r;
  assign valid = valid_r;
  assign entry = entry_r;
  assign dup   = dup_r;

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      dup_r <= valid_r && (entry_r.handle == cmp_entry.handle);
      gt_r  <= valid_r && ($signed(entry_r.prio) > $signed(cmp_entry.prio));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_place) begin
        entry_r <= left_entry;
      end else if (place) begin
        entry_r <= new_entry;
      end
    end else if (ctl.rem) begin
      entry_r <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.ins) begin
      if (left_place) begin
        valid_r <= left_valid;
      end else if (place) begin
        valid_r <= 1'b1;
      end
    end else if (ctl.rem) begin
      valid_r <= right_valid;
    end
  end

endmodule

@@ sv/stable_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                            | Handshake
// request  | in_req_type in_item_handle in_kind in_priority_req | start & !busy
// result   | out_status out_count out_handle out_kind out_priority | out_strobe
//
// For each request, the accept edge registers every cell's compare,
// the next edge shifts the cell row and registers the result.
// out_strobe is high in the cycle after that; a new request may be accepted then.
// busy is high for one cycle after each transfer.
// rst_n (synchronous) empties the queue; stored payload is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.

module stable_priority_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [15:0]        in_item_handle,
  input  logic [7:0]         in_kind,
  input  logic signed [15:0] in_priority_req,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [4:0]         out_count,
  output logic [15:0]        out_handle,
  output logic [7:0]         out_kind,
  output logic signed [15:0] out_priority
);

  localparam int D = spq_pkg::DEPTH;
  localparam int CW = spq_pkg::CNT_W;

  spq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             req_type_r;
  spq_pkg::entry_t  req_r;
  logic             strobe_r, strobe_nxt;
  spq_pkg::status_t status_r, status_nxt;
  spq_pkg::entry_t  res_r, res_nxt;

  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    cmp_entry;
  spq_pkg::entry_t    cell_entry [D];
  logic [D-1:0]       cell_valid;
  logic [D-1:0]       cell_place;
  logic [D-1:0]       cell_dup;
  logic               accept;

  assign accept = start && (state_r == spq_pkg::S_IDLE);
  assign busy   = (state_r == spq_pkg::S_APPLY);

  assign cmp_entry.handle = in_item_handle;
  assign cmp_entry.kind   = in_kind;
  assign cmp_entry.prio   = in_priority_req;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic            lp, lv, rv;
    spq_pkg::entry_t le, re;
    if (i == 0) begin : g_first
      assign lp = 1'b0;
      assign lv = 1'b0;
      assign le = '0;
    end else begin : g_mid
      assign lp = cell_place[i-1];
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
    end
    if (i == D - 1) begin : g_last
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cmp_entry   (cmp_entry),
      .new_entry   (req_r),
      .left_place  (lp),
      .left_valid  (lv),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .place       (cell_place[i]),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .dup         (cell_dup[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= spq_pkg::S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      req_r      <= cmp_entry;
    end
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    res_nxt    = res_r;
    ctl.eval   = accept;
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = spq_pkg::S_APPLY;
        end
      end
      spq_pkg::S_APPLY: begin
        state_nxt  = spq_pkg::S_IDLE;
        strobe_nxt = 1'b1;
        res_nxt    = '0;
        status_nxt = spq_pkg::ST_OK;
        if (req_type_r == spq_pkg::REQ_INSERT) begin
          if (req_r.handle == 16'd0) begin
            status_nxt = spq_pkg::ST_NULL;
          end else if (|cell_dup) begin
            status_nxt = spq_pkg::ST_DUP;
          end else if (cnt_r == CW'(D)) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          if (cnt_r == '0) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            ctl.rem = 1'b1;
            res_nxt = cell_entry[0];
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_count    = 5'(cnt_r);
  assign out_handle   = res_r.handle;
  assign out_kind     = res_r.kind;
  assign out_priority = res_r.prio;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(D))
    else $error("count exceeds depth");

  a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(cnt_r))
    else $error("valid cells disagree with count");

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == spq_pkg::S_APPLY))
    else $error("result without a request");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove together");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_strobe)
    else $error("request did not complete in two cycles");
`endif

endmodule

@@ tb/tb_stable_priority_queue_top.sv @@
`timescale 1ns / 1ps

module tb_stable_priority_queue_top;

  localparam int CYC_LIMIT = 200000;
  localparam int RAND_ITEMS = 400;
  localparam int CALM_FROM = 340;

  typedef struct {
    spq_pkg::status_t   status;
    logic [4:0]         count;
    logic [15:0]        handle;
    logic [7:0]         kind;
    logic signed [15:0] prio;
  } queue_resp_t;

  typedef struct {
    spq_pkg::req_t      req;
    logic [15:0]        handle;
    logic [7:0]         kind;
    logic signed [15:0] prio;
    bit                 typed;
    queue_resp_t        res;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_req_type;
  logic [15:0]        in_item_handle;
  logic [7:0]         in_kind;
  logic signed [15:0] in_priority_req;
  logic               out_strobe;
  logic [2:0]         out_status;
  logic [4:0]         out_count;
  logic [15:0]        out_handle;
  logic [7:0]         out_kind;
  logic signed [15:0] out_priority;

  spq_pkg::entry_t sorted_ent [spq_pkg::DEPTH];
  int              sorted_cnt;
  queue_resp_t     due_resp [$];
  queue_resp_t     seen_resp;
  stim_row_t       dir_tab [$];
  int              err_cnt;
  int              cyc_cnt;

  stable_priority_queue_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_item_handle  (in_item_handle),
    .in_kind         (in_kind),
    .in_priority_req (in_priority_req),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_handle      (out_handle),
    .out_kind        (out_kind),
    .out_priority    (out_priority)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stable sorted queue: insert goes after every entry of equal priority
  function automatic queue_resp_t apply_request(spq_pkg::req_t rq, logic [15:0] h,
                                                logic [7:0] k, logic signed [15:0] p);
    queue_resp_t r;
    bit          dup;
    int          pos;
    int          i;
    r.status = spq_pkg::ST_OK;
    r.handle = '0;
    r.kind   = '0;
    r.prio   = '0;
    dup      = 1'b0;
    if (rq == spq_pkg::REQ_INSERT) begin
      for (i = 0; i < sorted_cnt; i++) begin
        if (sorted_ent[i].handle == h) dup = 1'b1;
      end
      if (h == 16'd0) begin
        r.status = spq_pkg::ST_NULL;
      end else if (dup) begin
        r.status = spq_pkg::ST_DUP;
      end else if (sorted_cnt >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = sorted_cnt;
        for (i = sorted_cnt - 1; i >= 0; i--) begin
          if ($signed(sorted_ent[i].prio) > $signed(p)) pos = i;
        end
        for (i = sorted_cnt; i > pos; i--) sorted_ent[i] = sorted_ent[i-1];
        sorted_ent[pos].handle = h;
        sorted_ent[pos].kind   = k;
        sorted_ent[pos].prio   = p;
        sorted_cnt++;
      end
    end else begin
      if (sorted_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.handle = sorted_ent[0].handle;
        r.kind   = sorted_ent[0].kind;
        r.prio   = sorted_ent[0].prio;
        for (i = 1; i < sorted_cnt; i++) sorted_ent[i-1] = sorted_ent[i];
        sorted_cnt--;
      end
    end
    r.count = sorted_cnt[4:0];
    return r;
  endfunction

  function automatic void add_row(spq_pkg::req_t rq, logic [15:0] h, logic [7:0] k,
                                  logic signed [15:0] p, bit ty, spq_pkg::status_t st,
                                  logic [4:0] c, logic [15:0] oh, logic [7:0] ok,
                                  logic signed [15:0] op);
    stim_row_t row;
    row.req        = rq;
    row.handle     = h;
    row.kind       = k;
    row.prio       = p;
    row.typed      = ty;
    row.res.status = st;
    row.res.count  = c;
    row.res.handle = oh;
    row.res.kind   = ok;
    row.res.prio   = op;
    dir_tab.push_back(row);
  endfunction

  task automatic send_req(stim_row_t row);
    queue_resp_t model_r;
    @(negedge clk);
    start           <= 1'b1;
    in_req_type     <= row.req;
    in_item_handle  <= row.handle;
    in_kind         <= row.kind;
    in_priority_req <= row.prio;
    do @(posedge clk); while (busy);
    model_r = apply_request(row.req, row.handle, row.kind, row.prio);
    due_resp.push_back(row.typed ? row.res : model_r);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start           <= 1'b0;
    in_req_type     <= 1'($urandom);
    in_item_handle  <= 16'($urandom);
    in_kind         <= 8'($urandom);
    in_priority_req <= 16'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_resp.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0h", $time, out_status);
        err_cnt++;
      end else begin
        seen_resp = due_resp.pop_front();
        cmp_field("status", 16'(seen_resp.status), 16'(out_status));
        cmp_field("count", 16'(seen_resp.count), 16'(out_count));
        cmp_field("handle", seen_resp.handle, out_handle);
        cmp_field("kind", 16'(seen_resp.kind), 16'(out_kind));
        cmp_field("priority", seen_resp.prio, out_priority);
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYC_LIMIT) begin
      $display("tb_stable_priority_queue_top NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        n;
    int        ins_pct;
    int        pick;
    err_cnt         = 0;
    cyc_cnt         = 0;
    sorted_cnt      = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = spq_pkg::REQ_INSERT;
    in_item_handle  = '0;
    in_kind         = '0;
    in_priority_req = '0;

    add_row(spq_pkg::REQ_REMOVE, 16'h1234, 8'h55, 16'sh0100, 1,
            spq_pkg::ST_EMPTY, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0000, 8'hAA, 16'sh0005, 1,
            spq_pkg::ST_NULL, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'hFFFF, 8'hFF, 16'sh7FFF, 1,
            spq_pkg::ST_OK, 5'd1, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'hFFFF, 8'h01, 16'sh0000, 1,
            spq_pkg::ST_DUP, 5'd1, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0001, 8'h00, -16'sd32768, 1,
            spq_pkg::ST_OK, 5'd2, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h8000, 8'h80, 16'sh0000, 1,
            spq_pkg::ST_OK, 5'd3, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0002, 8'h7F, 16'sh0000, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    // fill to DEPTH with ties and extremes mixed in
    add_row(spq_pkg::REQ_INSERT, 16'h0003, 8'h11, 16'sd5, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0004, 8'h22, -16'sd5, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0005, 8'h33, 16'sd0, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0006, 8'h44, 16'sd0, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0007, 8'h55, 16'sd100, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0008, 8'h66, -16'sd100, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0009, 8'h77, 16'sd5, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h000A, 8'h88, 16'sh7FFF, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h000B, 8'h99, -16'sd32768, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h000C, 8'hCC, 16'sd0, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h000D, 8'hDD, 16'sd7, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h7FFF, 8'hEE, -16'sd1, 1,
            spq_pkg::ST_OK, 5'd16, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h00AA, 8'h5A, 16'sd3, 1,
            spq_pkg::ST_FULL, 5'd16, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h0000, 8'h5A, 16'sd3, 1,
            spq_pkg::ST_NULL, 5'd16, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_INSERT, 16'h8000, 8'h5A, 16'sd3, 1,
            spq_pkg::ST_DUP, 5'd16, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_REMOVE, 16'hFFFF, 8'hFF, 16'sh7FFF, 1,
            spq_pkg::ST_OK, 5'd15, 16'h0001, 8'h00, -16'sd32768);
    add_row(spq_pkg::REQ_REMOVE, 16'h0000, 8'h00, 16'sh0000, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);
    add_row(spq_pkg::REQ_REMOVE, 16'h0000, 8'h00, 16'sh0000, 0,
            spq_pkg::ST_OK, 5'd0, 16'h0, 8'h0, 16'sh0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i]);

    ins_pct = 70;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) ins_pct = $urandom_range(0, 1) ? 75 : 30;
      row.req   = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::REQ_INSERT
                                                    : spq_pkg::REQ_REMOVE;
      pick      = $urandom_range(0, 99);
      if (pick < 4) row.handle = 16'h0;
      else if (pick < 60) row.handle = 16'($urandom_range(1, 24));
      else row.handle = 16'($urandom);
      row.kind  = 8'($urandom);
      row.prio  = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 6) - 3) : 16'($urandom);
      row.typed = 1'b0;
      if (n < CALM_FROM && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 13));
      send_req(row);
    end

    idle_gap(1);
    while (due_resp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_stable_priority_queue_top OK");
    end else begin
      $display("tb_stable_priority_queue_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_top.sv
tb/tb_stable_priority_queue_top.sv
